FILE: src/ffbta_pkg.sv
`default_nettype none

package ffbta_pkg;

    // heap geometry
    localparam int HEAP_BYTES = 65536;
    localparam int TAG_WORDS  = HEAP_BYTES / 4;
    localparam int TAG_AW     = $clog2(TAG_WORDS);
    localparam int BA_W       = 17;
    localparam int BYTES_W    = 18;
    localparam int TAG_W      = 32;

    localparam logic [BA_W-1:0] WALK_START = 17'd8;
    localparam logic [BA_W-1:0] HEAP_CAP   = 17'(HEAP_BYTES);
    localparam logic [BA_W-1:0] INIT_END   = 17'd4112;
    localparam int              INIT_WORDS = 6;
    localparam int              INIT_CW    = $clog2(INIT_WORDS);

    // configuration registers
    localparam int CFG_W = 17;
    localparam logic [CFG_W-1:0] CHUNK_RESET = 17'd4096;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 17'd65536;
    localparam logic REG_CHUNK = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    // request and result codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_OOM  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    // datapath commands
    typedef enum logic [5:0] {
        CMD_NOP,
        CMD_INIT,
        CMD_START,
        CMD_DISP,
        CMD_WALK_RD,
        CMD_WALK_STEP,
        CMD_GROW_SZ,
        CMD_GROW_TST,
        CMD_GROW_RD,
        CMD_GROW_W0,
        CMD_GROW_W1,
        CMD_GROW_W2,
        CMD_MRG_RD0,
        CMD_MRG_RD1,
        CMD_MRG_CHK,
        CMD_MRG_PRD,
        CMD_MRG_PSUB,
        CMD_MRG_WH,
        CMD_MRG_WF,
        CMD_PLACE_RD,
        CMD_PLACE_LAT,
        CMD_PLACE_W0,
        CMD_PLACE_SW1,
        CMD_PLACE_SW2,
        CMD_PLACE_NRD,
        CMD_PLACE_NW,
        CMD_LIVE_RD,
        CMD_LIVE_STEP,
        CMD_REL_W0,
        CMD_REL_W1,
        CMD_REL_RD,
        CMD_REL_W2,
        CMD_EMIT
    } cmd_t;

    // datapath status toward the controller
    typedef struct packed {
        logic init_last;
        logic is_free;
        logic zero_req;
        logic in_range;
        logic s_zero;
        logic hit;
        logic bp_gt;
        logic bp_eq;
        logic live;
        logic grow_fail;
        logic prev_used;
        logic foot;
        logic rem_ge8;
    } dp_stat_t;

    // build a tag word from size and flag bits
    function automatic logic [TAG_W-1:0] mk_tag(input logic [BA_W-1:0] size,
                                                 input logic prev, input logic alloc);
        mk_tag = {{(TAG_W-BA_W){1'b0}}, size[BA_W-1:3], 1'b0, prev, alloc};
    endfunction

    // words written after reset: pad, prologue, first chunk, epilogue
    function automatic logic [BA_W-1:0] init_addr(input logic [INIT_CW-1:0] idx);
        case (idx)
            3'd0:    init_addr = 17'd0;
            3'd1:    init_addr = 17'd4;
            3'd2:    init_addr = 17'd8;
            3'd3:    init_addr = 17'd12;
            3'd4:    init_addr = 17'd4104;
            default: init_addr = 17'd4108;
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] init_data(input logic [INIT_CW-1:0] idx);
        case (idx)
            3'd0:    init_data = '0;
            3'd1:    init_data = mk_tag(17'd8, 1'b0, 1'b1);
            3'd2:    init_data = mk_tag(17'd8, 1'b0, 1'b1);
            3'd3:    init_data = mk_tag(17'd4096, 1'b1, 1'b0);
            3'd4:    init_data = mk_tag(17'd4096, 1'b0, 1'b0);
            default: init_data = mk_tag(17'd0, 1'b0, 1'b1);
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: src/ffbta_req_if.sv
`default_nettype none

interface ffbta_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] alloc_bytes;
    logic [15:0] block_addr;

    modport source (output valid, output req_type, output alloc_bytes, output block_addr,
                    input ready);
    modport sink (input valid, input req_type, input alloc_bytes, input block_addr,
                  output ready);
endinterface

`default_nettype wire

FILE: src/ffbta_rsp_if.sv
`default_nettype none

interface ffbta_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_addr;
    logic [1:0]  status;

    modport source (output valid, output result_addr, output status, input ready);
    modport sink (input valid, input result_addr, input status, output ready);
endinterface

`default_nettype wire

FILE: src/ffbta_ram.sv
`default_nettype none

module ffbta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/ffbta_dp.sv
`default_nettype none

module ffbta_dp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ffbta_pkg::cmd_t            cmd,
    input  wire logic                       in_req_type,
    input  wire logic [15:0]                in_alloc_bytes,
    input  wire logic [15:0]                in_block_addr,
    input  wire logic [ffbta_pkg::CFG_W-1:0] chunk_bytes,
    input  wire logic [ffbta_pkg::CFG_W-1:0] heap_limit,
    output ffbta_pkg::dp_stat_t             stat,
    output logic [15:0]                     result_addr,
    output logic [1:0]                      status
);
    import ffbta_pkg::*;

    logic [INIT_CW-1:0] init_reg;
    logic [BA_W-1:0]    heap_end_reg;
    logic [BA_W-1:0]    bp_reg;
    logic [BA_W-1:0]    asize_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [BA_W-1:0]    size_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               prev_reg;
    logic               foot_reg;
    logic               req_reg;
    logic [15:0]        nbytes_reg;
    logic [15:0]        addr_reg;
    logic [15:0]        res_addr_reg;
    logic [1:0]         res_stat_reg;
    logic [15:0]        out_addr_reg;
    logic [1:0]         out_stat_reg;

    logic               mem_we;
    logic [BA_W-1:0]    mem_ba;
    logic [TAG_W-1:0]   mem_wdata;
    logic [TAG_W-1:0]   rdata;

    logic [BA_W-1:0]    rd_size;
    logic [BA_W-1:0]    tag_size;
    logic [BA_W-1:0]    bytes17;
    logic [BA_W-1:0]    rem;
    logic [BA_W-1:0]    asize_new;
    logic [BA_W-1:0]    nb_sum;
    logic [BYTES_W-1:0] chunk_r;
    logic [BYTES_W-1:0] chunk_sum;
    logic [BA_W-1:0]    limit;
    logic [BYTES_W:0]   end_sum;

    ffbta_ram #(.WIDTH(TAG_W), .DEPTH(TAG_WORDS)) u_tags (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_ba[TAG_AW+1:2]),
        .wdata (mem_wdata),
        .rdata (rdata)
    );

    // field decode and arithmetic
    assign rd_size   = {rdata[BA_W-1:3], 3'b000};
    assign tag_size  = {tag_reg[BA_W-1:3], 3'b000};
    assign bytes17   = bytes_reg[BA_W-1:0];
    assign rem       = tag_size - asize_reg;
    assign nb_sum    = {1'b0, in_alloc_bytes} + 17'd11;
    assign asize_new = (in_alloc_bytes <= 16'd4) ? 17'd8 : {nb_sum[BA_W-1:3], 3'b000};
    assign chunk_sum = {1'b0, chunk_bytes} + 18'd7;
    assign chunk_r   = {chunk_sum[BYTES_W-1:3], 3'b000};
    assign limit     = (heap_limit < HEAP_CAP) ? heap_limit : HEAP_CAP;
    assign end_sum   = {2'b00, heap_end_reg} + {1'b0, bytes_reg};

    // status toward the controller
    always_comb
    begin
        stat.init_last  = (init_reg == INIT_CW'(INIT_WORDS - 1));
        stat.is_free    = (req_reg == REQ_FREE);
        stat.zero_req   = (nbytes_reg == 16'd0);
        stat.in_range   = (bp_reg >= WALK_START) && (bp_reg <= heap_end_reg);
        stat.s_zero     = (rd_size == '0);
        stat.hit        = !rdata[0] && (asize_reg <= rd_size);
        stat.bp_gt      = (bp_reg > {1'b0, addr_reg});
        stat.bp_eq      = (bp_reg == {1'b0, addr_reg});
        stat.live       = stat.bp_eq && (bp_reg != WALK_START) && rdata[0];
        stat.grow_fail  = (bytes_reg == '0) || (bytes_reg > {1'b0, limit})
                          || (end_sum > {2'b00, limit});
        stat.prev_used  = prev_reg;
        stat.foot       = foot_reg;
        stat.rem_ge8    = ({1'b0, tag_size} >= ({1'b0, asize_reg} + 18'd8));
    end

    // tag memory address and write data
    always_comb
    begin
        mem_we    = 1'b0;
        mem_ba    = bp_reg - 17'd4;
        mem_wdata = '0;
        case (cmd)
            CMD_INIT:
            begin
                mem_we    = 1'b1;
                mem_ba    = init_addr(init_reg);
                mem_wdata = init_data(init_reg);
            end
            CMD_GROW_RD:   mem_ba = heap_end_reg - 17'd4;
            CMD_GROW_W0:
            begin
                mem_we    = 1'b1;
                mem_wdata = mk_tag(bytes17, rdata[1], 1'b0);
            end
            CMD_GROW_W1:
            begin
                mem_we    = 1'b1;
                mem_ba    = bp_reg + bytes17 - 17'd8;
                mem_wdata = mk_tag(bytes17, 1'b0, 1'b0);
            end
            CMD_GROW_W2:
            begin
                mem_we    = 1'b1;
                mem_ba    = bp_reg + bytes17 - 17'd4;
                mem_wdata = mk_tag('0, 1'b0, 1'b1);
            end
            CMD_MRG_RD1:   mem_ba = bp_reg + rd_size - 17'd4;
            CMD_MRG_PRD:   mem_ba = bp_reg - 17'd8;
            CMD_MRG_WH:
            begin
                mem_we    = 1'b1;
                mem_wdata = mk_tag(size_reg, 1'b1, 1'b0);
            end
            CMD_MRG_WF:
            begin
                mem_we    = 1'b1;
                mem_ba    = bp_reg + size_reg - 17'd8;
                mem_wdata = mk_tag(size_reg, 1'b0, 1'b0);
            end
            CMD_PLACE_W0:
            begin
                mem_we    = 1'b1;
                mem_wdata = mk_tag(stat.rem_ge8 ? asize_reg : tag_size, tag_reg[1], 1'b1);
            end
            CMD_PLACE_SW1:
            begin
                mem_we    = 1'b1;
                mem_ba    = bp_reg + asize_reg - 17'd4;
                mem_wdata = mk_tag(rem, 1'b1, 1'b0);
            end
            CMD_PLACE_SW2:
            begin
                mem_we    = 1'b1;
                mem_ba    = bp_reg + tag_size - 17'd8;
                mem_wdata = mk_tag(rem, 1'b0, 1'b0);
            end
            CMD_PLACE_NRD: mem_ba = bp_reg + tag_size - 17'd4;
            CMD_PLACE_NW:
            begin
                mem_we    = 1'b1;
                mem_ba    = bp_reg + tag_size - 17'd4;
                mem_wdata = rdata | TAG_W'(2);
            end
            CMD_REL_W0:
            begin
                mem_we    = 1'b1;
                mem_wdata = mk_tag(tag_size, tag_reg[1], 1'b0);
            end
            CMD_REL_W1:
            begin
                mem_we    = 1'b1;
                mem_ba    = bp_reg + tag_size - 17'd8;
                mem_wdata = mk_tag(tag_size, 1'b0, 1'b0);
            end
            CMD_REL_RD:    mem_ba = bp_reg + tag_size - 17'd4;
            CMD_REL_W2:
            begin
                mem_we    = 1'b1;
                mem_ba    = bp_reg + tag_size - 17'd4;
                mem_wdata = rdata & ~TAG_W'(2);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // control state: init counter and heap end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg     <= '0;
            heap_end_reg <= INIT_END;
        end
        else
        begin
            if (cmd == CMD_INIT && !stat.init_last)
            begin
                init_reg <= init_reg + 1'b1;
            end
            if (cmd == CMD_GROW_W2)
            begin
                heap_end_reg <= heap_end_reg + bytes17;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd) inside
            CMD_START:
            begin
                req_reg    <= in_req_type;
                nbytes_reg <= in_alloc_bytes;
                addr_reg   <= in_block_addr;
                asize_reg  <= asize_new;
                bp_reg     <= WALK_START;
            end
            CMD_DISP:
            begin
                res_addr_reg <= '0;
                res_stat_reg <= (!stat.is_free && stat.zero_req) ? STAT_ZERO : STAT_OK;
            end
            CMD_WALK_STEP:
            begin
                if (!stat.s_zero && !stat.hit)
                begin
                    bp_reg <= bp_reg + rd_size;
                end
            end
            CMD_GROW_SZ:
            begin
                bytes_reg <= ({1'b0, asize_reg} > chunk_r) ? {1'b0, asize_reg} : chunk_r;
            end
            CMD_GROW_TST:
            begin
                if (stat.grow_fail)
                begin
                    res_stat_reg <= STAT_OOM;
                end
            end
            CMD_GROW_RD:   bp_reg <= heap_end_reg;
            CMD_MRG_RD1:
            begin
                size_reg <= rd_size;
                prev_reg <= rdata[1];
            end
            CMD_MRG_CHK:
            begin
                if (!rdata[0])
                begin
                    size_reg <= size_reg + rd_size;
                end
                foot_reg <= !(prev_reg && rdata[0]);
            end
            CMD_MRG_PSUB:
            begin
                bp_reg   <= bp_reg - rd_size;
                size_reg <= size_reg + rd_size;
            end
            CMD_PLACE_LAT: tag_reg <= rdata;
            CMD_PLACE_SW2, CMD_PLACE_NW:
            begin
                res_addr_reg <= bp_reg[15:0];
                res_stat_reg <= STAT_OK;
            end
            CMD_LIVE_STEP:
            begin
                tag_reg <= rdata;
                if (!stat.s_zero && !stat.bp_gt && !stat.bp_eq)
                begin
                    bp_reg <= bp_reg + rd_size;
                end
            end
            CMD_EMIT:
            begin
                out_addr_reg <= res_addr_reg;
                out_stat_reg <= res_stat_reg;
            end
            default:
            begin
                res_addr_reg <= res_addr_reg;
            end
        endcase
    end

    assign result_addr = out_addr_reg;
    assign status      = out_stat_reg;

endmodule

`default_nettype wire

FILE: src/ffbta_ctrl.sv
`default_nettype none

module ffbta_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ffbta_pkg::dp_stat_t stat,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ffbta_pkg::cmd_t          cmd
);
    import ffbta_pkg::*;

    typedef enum logic [31:0] {
        S_INIT      = 32'h0000_0001,
        S_IDLE      = 32'h0000_0002,
        S_DISP      = 32'h0000_0004,
        S_FIND_RD   = 32'h0000_0008,
        S_FIND_CHK  = 32'h0000_0010,
        S_GROW_SZ   = 32'h0000_0020,
        S_GROW_TST  = 32'h0000_0040,
        S_GROW_RD   = 32'h0000_0080,
        S_GROW_W0   = 32'h0000_0100,
        S_GROW_W1   = 32'h0000_0200,
        S_GROW_W2   = 32'h0000_0400,
        S_MRG_RD0   = 32'h0000_0800,
        S_MRG_RD1   = 32'h0000_1000,
        S_MRG_CHK   = 32'h0000_2000,
        S_MRG_PRD   = 32'h0000_4000,
        S_MRG_PSUB  = 32'h0000_8000,
        S_MRG_WH    = 32'h0001_0000,
        S_MRG_WF    = 32'h0002_0000,
        S_PLACE_RD  = 32'h0004_0000,
        S_PLACE_LAT = 32'h0008_0000,
        S_PLACE_W0  = 32'h0010_0000,
        S_PLACE_SW1 = 32'h0020_0000,
        S_PLACE_SW2 = 32'h0040_0000,
        S_PLACE_NRD = 32'h0080_0000,
        S_PLACE_NW  = 32'h0100_0000,
        S_LIVE_RD   = 32'h0200_0000,
        S_LIVE_CHK  = 32'h0400_0000,
        S_REL_W0    = 32'h0800_0000,
        S_REL_W1    = 32'h1000_0000,
        S_REL_RD    = 32'h2000_0000,
        S_REL_W2    = 32'h4000_0000,
        S_DONE      = 32'h8000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    state_t merge_exit;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign slot_free  = !out_valid_reg || out_ready;
    assign merge_exit = stat.is_free ? S_DONE : S_PLACE_RD;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd            = CMD_NOP;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_INIT:
            begin
                cmd = CMD_INIT;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_START;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd = CMD_DISP;
                if (stat.is_free)
                begin
                    state_next = S_LIVE_RD;
                end
                else if (stat.zero_req)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIND_RD;
                end
            end
            // first-fit walk
            S_FIND_RD:
            begin
                cmd        = CMD_WALK_RD;
                state_next = stat.in_range ? S_FIND_CHK : S_GROW_SZ;
            end
            S_FIND_CHK:
            begin
                cmd = CMD_WALK_STEP;
                if (stat.s_zero)
                begin
                    state_next = S_GROW_SZ;
                end
                else if (stat.hit)
                begin
                    state_next = S_PLACE_RD;
                end
                else
                begin
                    state_next = S_FIND_RD;
                end
            end
            // heap growth
            S_GROW_SZ:
            begin
                cmd        = CMD_GROW_SZ;
                state_next = S_GROW_TST;
            end
            S_GROW_TST:
            begin
                cmd        = CMD_GROW_TST;
                state_next = stat.grow_fail ? S_DONE : S_GROW_RD;
            end
            S_GROW_RD:
            begin
                cmd        = CMD_GROW_RD;
                state_next = S_GROW_W0;
            end
            S_GROW_W0:
            begin
                cmd        = CMD_GROW_W0;
                state_next = S_GROW_W1;
            end
            S_GROW_W1:
            begin
                cmd        = CMD_GROW_W1;
                state_next = S_GROW_W2;
            end
            S_GROW_W2:
            begin
                cmd        = CMD_GROW_W2;
                state_next = S_MRG_RD0;
            end
            // coalesce
            S_MRG_RD0:
            begin
                cmd        = CMD_MRG_RD0;
                state_next = S_MRG_RD1;
            end
            S_MRG_RD1:
            begin
                cmd        = CMD_MRG_RD1;
                state_next = S_MRG_CHK;
            end
            S_MRG_CHK:
            begin
                cmd        = CMD_MRG_CHK;
                state_next = stat.prev_used ? S_MRG_WH : S_MRG_PRD;
            end
            S_MRG_PRD:
            begin
                cmd        = CMD_MRG_PRD;
                state_next = S_MRG_PSUB;
            end
            S_MRG_PSUB:
            begin
                cmd        = CMD_MRG_PSUB;
                state_next = S_MRG_WH;
            end
            S_MRG_WH:
            begin
                cmd        = CMD_MRG_WH;
                state_next = stat.foot ? S_MRG_WF : merge_exit;
            end
            S_MRG_WF:
            begin
                cmd        = CMD_MRG_WF;
                state_next = merge_exit;
            end
            // placement with optional split
            S_PLACE_RD:
            begin
                cmd        = CMD_PLACE_RD;
                state_next = S_PLACE_LAT;
            end
            S_PLACE_LAT:
            begin
                cmd        = CMD_PLACE_LAT;
                state_next = S_PLACE_W0;
            end
            S_PLACE_W0:
            begin
                cmd        = CMD_PLACE_W0;
                state_next = stat.rem_ge8 ? S_PLACE_SW1 : S_PLACE_NRD;
            end
            S_PLACE_SW1:
            begin
                cmd        = CMD_PLACE_SW1;
                state_next = S_PLACE_SW2;
            end
            S_PLACE_SW2:
            begin
                cmd        = CMD_PLACE_SW2;
                state_next = S_DONE;
            end
            S_PLACE_NRD:
            begin
                cmd        = CMD_PLACE_NRD;
                state_next = S_PLACE_NW;
            end
            S_PLACE_NW:
            begin
                cmd        = CMD_PLACE_NW;
                state_next = S_DONE;
            end
            // free: check the block is live, then release
            S_LIVE_RD:
            begin
                cmd        = CMD_LIVE_RD;
                state_next = stat.in_range ? S_LIVE_CHK : S_DONE;
            end
            S_LIVE_CHK:
            begin
                cmd = CMD_LIVE_STEP;
                if (stat.s_zero || stat.bp_gt)
                begin
                    state_next = S_DONE;
                end
                else if (stat.bp_eq)
                begin
                    state_next = stat.live ? S_REL_W0 : S_DONE;
                end
                else
                begin
                    state_next = S_LIVE_RD;
                end
            end
            S_REL_W0:
            begin
                cmd        = CMD_REL_W0;
                state_next = S_REL_W1;
            end
            S_REL_W1:
            begin
                cmd        = CMD_REL_W1;
                state_next = S_REL_RD;
            end
            S_REL_RD:
            begin
                cmd        = CMD_REL_RD;
                state_next = S_REL_W2;
            end
            S_REL_W2:
            begin
                cmd        = CMD_REL_W2;
                state_next = S_MRG_RD0;
            end
            // hand the result to the output register
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd            = CMD_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/first_fit_boundary_tag_allocator.sv
// First-fit boundary-tag heap allocator over a 64 KiB heap kept as 4-byte tag
// words in one single-port RAM. After reset the block writes the prologue, the
// first 4096-byte chunk and the epilogue before it takes a request. Every
// request passes through accept, dispatch and the hand-off to the output
// register (a zero-size allocate takes only these steps). An allocate visits
// blocks from the start of the heap, then places the block it found; a miss
// first grows the heap and coalesces the new chunk, or stops after sizing and
// testing the growth when it would pass the limit. A free walks the block list
// the same way up to the target and then releases and coalesces the block.
// Every step is bound by the one tag RAM port, which does a single read or
// write per cycle. One request is in work at a time; its result sits in an
// output register while the next request is taken, and the hand-off waits
// while that register still holds an unread result. Configuration:
// chunk_bytes at address 0, heap_limit at address 4.
`default_nettype none

module first_fit_boundary_tag_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ffbta_req_if.sink        req,
    ffbta_rsp_if.source      rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import ffbta_pkg::*;

    logic [CFG_W-1:0] chunk_reg;
    logic [CFG_W-1:0] limit_reg;
    cmd_t             cmd;
    dp_stat_t         stat;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= CHUNK_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_CHUNK: chunk_reg <= pwdata[CFG_W-1:0];
                REG_LIMIT: limit_reg <= pwdata[CFG_W-1:0];
                default:   chunk_reg <= chunk_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_LIMIT) ? {{(32-CFG_W){1'b0}}, limit_reg}
                                            : {{(32-CFG_W){1'b0}}, chunk_reg};

    ffbta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    ffbta_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .in_req_type    (req.req_type),
        .in_alloc_bytes (req.alloc_bytes),
        .in_block_addr  (req.block_addr),
        .chunk_bytes    (chunk_reg),
        .heap_limit     (limit_reg),
        .stat           (stat),
        .result_addr    (rsp.result_addr),
        .status         (rsp.status)
    );

endmodule

`default_nettype wire

FILE: tb/heap_shadow_checker.sv
`timescale 1ns / 1ps

module heap_shadow_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ffbta_req_if             req,
    ffbta_rsp_if             rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending_count
);
    import ffbta_pkg::*;

    typedef struct {
        logic [15:0] result_addr;
        logic [1:0]  status;
    } reply_t;

    // shadow heap state
    logic [31:0] shadow_tags [0:TAG_WORDS-1];
    int unsigned heap_end;
    int unsigned walk_start;
    int unsigned chunk_bytes;
    int unsigned heap_limit;

    reply_t awaited_replies [$];

    localparam int unsigned SZ_MASK = 32'hFFFF_FFF8;
    localparam int unsigned A_BIT   = 32'h1;
    localparam int unsigned P_BIT   = 32'h2;

    function automatic int unsigned tag_get(int unsigned a);
        int unsigned idx;
        idx = a >> 2;
        return (idx < TAG_WORDS) ? shadow_tags[idx] : 0;
    endfunction

    function automatic void tag_put(int unsigned a, int unsigned v);
        int unsigned idx;
        idx = a >> 2;
        if (idx < TAG_WORDS)
            shadow_tags[idx] = v;
    endfunction

    // coalesce a free block with free neighbors
    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned size;
        int unsigned nxt;
        int unsigned psize;
        bit          next_used;
        bit          prev_used;
        size = tag_get(bp - 4) & SZ_MASK;
        nxt = bp + size;
        next_used = (tag_get(nxt - 4) & A_BIT) != 0;
        prev_used = (tag_get(bp - 4) & P_BIT) != 0;
        if (prev_used && next_used)
        begin
            tag_put(bp - 4, size | P_BIT);
            return bp;
        end
        if (!next_used)
            size += tag_get(nxt - 4) & SZ_MASK;
        if (!prev_used)
        begin
            psize = tag_get(bp - 8) & SZ_MASK;
            bp -= psize;
            size += psize;
        end
        tag_put(bp - 4, size | P_BIT);
        tag_put(bp + size - 8, size);
        return bp;
    endfunction

    function automatic int unsigned grow_heap(int unsigned bytes);
        int unsigned lim;
        int unsigned bp;
        int unsigned pa;
        lim = (heap_limit < HEAP_BYTES) ? heap_limit : HEAP_BYTES;
        bp = heap_end;
        if (bytes == 0 || bytes > lim || heap_end > lim - bytes)
            return 0;
        pa = tag_get(bp - 4) & P_BIT;
        tag_put(bp - 4, bytes | pa);
        tag_put(bp + bytes - 8, bytes);
        tag_put(bp + bytes - 4, A_BIT);
        heap_end += bytes;
        return coalesce(bp);
    endfunction

    function automatic int unsigned first_fit(int unsigned asize);
        int unsigned bp;
        int unsigned t;
        int unsigned s;
        bp = walk_start;
        while (bp >= 8 && bp <= heap_end)
        begin
            t = tag_get(bp - 4);
            s = t & SZ_MASK;
            if (s == 0)
                break;
            if ((t & A_BIT) == 0 && asize <= s)
                return bp;
            bp += s;
        end
        return 0;
    endfunction

    function automatic void carve_block(int unsigned bp, int unsigned asize);
        int unsigned t;
        int unsigned full;
        int unsigned pa;
        int unsigned rem;
        int unsigned nb;
        t = tag_get(bp - 4);
        full = t & SZ_MASK;
        pa = t & P_BIT;
        rem = full - asize;
        if (rem >= 8)
        begin
            nb = bp + asize;
            tag_put(bp - 4, asize | pa | A_BIT);
            tag_put(nb - 4, rem | P_BIT);
            tag_put(nb + rem - 8, rem);
        end
        else
        begin
            nb = bp + full;
            tag_put(bp - 4, full | pa | A_BIT);
            tag_put(nb - 4, tag_get(nb - 4) | P_BIT);
        end
    endfunction

    function automatic bit is_allocated_block(int unsigned addr);
        int unsigned bp;
        int unsigned t;
        int unsigned s;
        bp = walk_start;
        while (bp >= 8 && bp <= heap_end)
        begin
            t = tag_get(bp - 4);
            s = t & SZ_MASK;
            if (s == 0 || bp > addr)
                return 0;
            if (bp == addr)
                return bp != walk_start && (t & A_BIT) != 0;
            bp += s;
        end
        return 0;
    endfunction

    function automatic void release_block(int unsigned addr);
        int unsigned t;
        int unsigned size;
        int unsigned nh;
        int unsigned dummy;
        t = tag_get(addr - 4);
        size = t & SZ_MASK;
        nh = addr + size - 4;
        tag_put(addr - 4, size | (t & P_BIT));
        tag_put(addr + size - 8, size);
        tag_put(nh, tag_get(nh) & ~P_BIT);
        dummy = coalesce(addr);
    endfunction

    function automatic void rebuild_heap();
        int unsigned dummy;
        foreach (shadow_tags[i])
            shadow_tags[i] = '0;
        chunk_bytes = 4096;
        heap_limit = 65536;
        walk_start = 8;
        tag_put(4, 8 | A_BIT);
        tag_put(8, 8 | A_BIT);
        tag_put(12, P_BIT | A_BIT);
        heap_end = 16;
        dummy = grow_heap(4096);
    endfunction

    // work out the reply for one request beat
    function automatic reply_t serve_request(logic rt, logic [15:0] nbytes, logic [15:0] addr);
        reply_t      r;
        int unsigned asize;
        int unsigned chunk;
        int unsigned bp;
        r.result_addr = '0;
        r.status = STAT_OK;
        if (rt == REQ_ALLOC)
        begin
            if (nbytes == 0)
                r.status = STAT_ZERO;
            else
            begin
                asize = (nbytes <= 4) ? 8 : 8 * ((int'(nbytes) + 11) / 8);
                bp = first_fit(asize);
                if (bp == 0)
                begin
                    chunk = (chunk_bytes + 7) & SZ_MASK;
                    bp = grow_heap(asize > chunk ? asize : chunk);
                end
                if (bp == 0)
                    r.status = STAT_OOM;
                else
                begin
                    carve_block(bp, asize);
                    r.result_addr = bp[15:0];
                end
            end
        end
        else if (is_allocated_block(addr))
            release_block(addr);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            rebuild_heap();
            awaited_replies.delete();
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_CHUNK)
                    chunk_bytes = pwdata & 32'h1FFFF;
                else
                    heap_limit = pwdata & 32'h1FFFF;
            end
            // compare result beat against oldest expectation
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: unexpected result beat addr=%0d status=%0d",
                             $time, rsp.result_addr, rsp.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (want.result_addr !== rsp.result_addr || want.status !== rsp.status)
                    begin
                        $display("%0t: mismatch expected addr=%0d status=%0d, got addr=%0d status=%0d",
                                 $time, want.result_addr, want.status,
                                 rsp.result_addr, rsp.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // predict each request beat
            if (req.valid && req.ready)
                awaited_replies.push_back(serve_request(req.req_type, req.alloc_bytes,
                                                        req.block_addr));
            pending_count <= awaited_replies.size();
        end
    end

endmodule

FILE: tb/tb_first_fit_boundary_tag_allocator.sv
`timescale 1ns / 1ps

module tb_first_fit_boundary_tag_allocator;
    import ffbta_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;

    ffbta_req_if req ();
    ffbta_rsp_if rsp ();

    first_fit_boundary_tag_allocator dut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    heap_shadow_checker checker_i (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    int          req_beats;
    int          rsp_beats;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_asks;
    int          hold_seen;
    int          hold_left;
    logic [15:0] live_blocks [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // beat counters and live block list
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_beats <= 0;
            rsp_beats <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                req_beats <= req_beats + 1;
            if (rsp.valid && rsp.ready)
            begin
                rsp_beats <= rsp_beats + 1;
                if (rsp.status == STAT_OK && rsp.result_addr != 0)
                    live_blocks.push_back(rsp.result_addr);
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_beat(logic rt, logic [15:0] nbytes, logic [15:0] addr);
        int target;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= rt;
        req.alloc_bytes <= nbytes;
        req.block_addr <= addr;
        target = req_beats + 1;
        do
            @(negedge clk);
        while (req_beats != target);
    endtask

    // wait until every result is back, then let the block settle
    task automatic drain();
        req.valid <= 1'b0;
        @(negedge clk);
        while (rsp_beats != req_beats)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic free_live(int offset);
        int          k;
        logic [15:0] a;
        k = $urandom_range(live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        send_beat(REQ_FREE, 16'($urandom), a + 16'(offset));
    endtask

    task automatic random_beats(int count);
        int          sel;
        logic [15:0] nbytes;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (live_blocks.size() > 0 && (sel < 40 || (live_blocks.size() > 60 && sel < 70)))
                free_live(0);
            else if (sel >= 95)
                send_beat(REQ_FREE, 16'($urandom), 16'($urandom));
            else
            begin
                sel = $urandom_range(99);
                if (sel < 3)
                    nbytes = 0;
                else if (sel < 80)
                    nbytes = 16'($urandom_range(1, 128));
                else if (sel < 95)
                    nbytes = 16'($urandom_range(129, 2048));
                else if (sel < 98)
                    nbytes = 16'($urandom_range(2049, 16384));
                else
                    nbytes = 16'($urandom);
                send_beat(REQ_ALLOC, nbytes, 16'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.req_type = REQ_ALLOC;
        req.alloc_bytes = '0;
        req.block_addr = '0;
        tx_idle_pct = 32;
        rx_idle_pct = 53;
        hold_asks = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: size corners, bad frees, overflow
        send_beat(REQ_ALLOC, 16'd0, 16'hFFFF);
        send_beat(REQ_ALLOC, 16'd1, 16'd0);
        send_beat(REQ_ALLOC, 16'd4, 16'd0);
        send_beat(REQ_ALLOC, 16'd5, 16'd0);
        send_beat(REQ_ALLOC, 16'd12, 16'd0);
        send_beat(REQ_ALLOC, 16'd13, 16'd0);
        send_beat(REQ_ALLOC, 16'hFFFF, 16'd0);
        send_beat(REQ_ALLOC, 16'd5000, 16'd0);
        drain();
        send_beat(REQ_FREE, 16'd0, live_blocks[1]);
        send_beat(REQ_FREE, 16'd0, live_blocks[1]);
        send_beat(REQ_FREE, 16'd0, live_blocks[2] + 16'd8);
        send_beat(REQ_FREE, 16'd0, 16'd8);
        send_beat(REQ_FREE, 16'd0, 16'd0);
        send_beat(REQ_FREE, 16'hFFFF, 16'hFFFF);
        send_beat(REQ_FREE, 16'd0, live_blocks[0]);
        send_beat(REQ_FREE, 16'd0, live_blocks[3]);
        send_beat(REQ_ALLOC, 16'd2, 16'd0);
        send_beat(REQ_ALLOC, 16'd60000, 16'd0);
        send_beat(REQ_ALLOC, 16'd3000, 16'd0);
        drain();
        live_blocks.delete(3);
        live_blocks.delete(1);
        live_blocks.delete(0);

        // smallest nonzero chunk, sender and receiver idle
        write_reg(REG_CHUNK, 8);
        write_reg(REG_LIMIT, 65536);
        tx_idle_pct = 32;
        rx_idle_pct = 53;
        random_beats(100);
        drain();
        random_beats(100);
        drain();

        // tiny limit: every growth fails
        write_reg(REG_CHUNK, 65536);
        write_reg(REG_LIMIT, 32);
        random_beats(40);
        drain();

        // zero chunk, mid limit, receiver stalls long
        write_reg(REG_CHUNK, 0);
        write_reg(REG_LIMIT, 20000);
        tx_idle_pct = 53;
        rx_idle_pct = 32;
        hold_asks = hold_asks + 1;
        random_beats(180);
        drain();

        // back to reset values, receiver stalls long, then no idling
        write_reg(REG_CHUNK, 4096);
        write_reg(REG_LIMIT, 65536);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_asks = hold_asks + 1;
        random_beats(180);
        drain();

        if (fail_count == 0 && pending_count == 0)
            $display("tb_first_fit_boundary_tag_allocator: PASS");
        else
            $display("tb_first_fit_boundary_tag_allocator: FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("tb_first_fit_boundary_tag_allocator: FAIL");
        $finish;
    end

endmodule
